// ===== hw/rtl/csd_pkg.sv =====
// ============================================================================
// csd_pkg: shared types and constants for the checksummed sentence decoder
// Character codes, decoder state encodings, keyword recognizer and the
// result word carried from the parser to the output register.
// ============================================================================
package csd_pkg;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;

    // Sentence kinds as reported on the result channel
    localparam logic [2:0] KIND_CHA = 3'd0;
    localparam logic [2:0] KIND_ACC = 3'd1;
    localparam logic [2:0] KIND_REV = 3'd2;
    localparam logic [2:0] KIND_SHO = 3'd3;
    localparam logic [2:0] KIND_RES = 3'd4;

    // Field counts (keyword plus numbers) per sentence kind
    localparam logic [2:0] NEED_ONE   = 3'd2;
    localparam logic [2:0] NEED_TWO   = 3'd3;
    localparam logic [2:0] NEED_THREE = 3'd4;
    localparam logic [2:0] FIELD_MAX  = 3'd7;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_CHECK   = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        NP_LEAD   = 2'd0,
        NP_DIGITS = 2'd1,
        NP_DONE   = 2'd2
    } num_phase_t;

    typedef enum logic [3:0] {
        KW_START = 4'd0,
        KW_C     = 4'd1,
        KW_CH    = 4'd2,
        KW_CHA   = 4'd3,
        KW_A     = 4'd4,
        KW_AC    = 4'd5,
        KW_ACC   = 4'd6,
        KW_R     = 4'd7,
        KW_RE    = 4'd8,
        KW_REV   = 4'd9,
        KW_RES   = 4'd10,
        KW_S     = 4'd11,
        KW_SH    = 4'd12,
        KW_SHO   = 4'd13,
        KW_FAIL  = 4'd15
    } kw_t;

    // One result word
    typedef struct packed {
        logic        error_flag;
        logic        event_valid;
        logic [2:0]  event_kind;
        logic [15:0] value_a;
        logic [15:0] value_b;
        logic [15:0] value_c;
    } csd_result_t;

    // Keyword recognizer step
    function automatic kw_t kw_next(kw_t s, logic [7:0] c);
        kw_t r;
        r = KW_FAIL;
        case (s)
            KW_START: begin
                if (c == 8'h43)      r = KW_C;
                else if (c == 8'h41) r = KW_A;
                else if (c == 8'h52) r = KW_R;
                else if (c == 8'h53) r = KW_S;
            end
            KW_C:  if (c == 8'h48) r = KW_CH;
            KW_CH: if (c == 8'h41) r = KW_CHA;
            KW_A:  if (c == 8'h43) r = KW_AC;
            KW_AC: if (c == 8'h43) r = KW_ACC;
            KW_R:  if (c == 8'h45) r = KW_RE;
            KW_RE: begin
                if (c == 8'h56)      r = KW_REV;
                else if (c == 8'h53) r = KW_RES;
            end
            KW_S:  if (c == 8'h48) r = KW_SH;
            KW_SH: if (c == 8'h4F) r = KW_SHO;
            default: r = KW_FAIL;
        endcase
        return r;
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // Hex digit value; anything outside 0-9 / A-F reads as zero
    function automatic logic [3:0] hex_value(logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (is_digit(c))                       d = c - CH_ZERO;
        else if (c >= CH_UP_A && c <= CH_UP_F) d = c - CH_UP_A + 8'd10;
        return d[3:0];
    endfunction

endpackage

// ===== hw/rtl/csd_parser.sv =====
// ============================================================================
// csd_parser: sentence state and per-word decode
// Holds the sentence state, advances it by one received word when step_en
// is high, and presents the result word for that byte combinationally.
// ============================================================================
module csd_parser #(
    parameter int MAX_PAYLOAD = 128
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step_en,
    input  logic [7:0]           rx_byte,
    output csd_pkg::csd_result_t result
);

    localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_PAYLOAD);

    // State registers
    csd_pkg::phase_t     phase_reg,   phase_next;
    logic [CNT_W-1:0]    pcount_reg,  pcount_next;
    logic [7:0]          xor_reg,     xor_next;
    logic [1:0]          hexcnt_reg,  hexcnt_next;
    logic [7:0]          rxsum_reg,   rxsum_next;
    csd_pkg::kw_t        kw_reg,      kw_next_s;
    logic [2:0]          fcount_reg,  fcount_next;
    logic                infield_reg, infield_next;
    csd_pkg::num_phase_t np_reg,      np_next;
    logic                neg_reg,     neg_next;
    logic [15:0]         cur_reg,     cur_next;
    logic [15:0]         num0_reg,    num0_next;
    logic [15:0]         num1_reg,    num1_next;
    logic [15:0]         num2_reg,    num2_next;

    // Field view after a possible field start
    logic [2:0]          fc_f;
    csd_pkg::num_phase_t np_f;
    logic                neg_f;
    logic [15:0]         cur_f;

    // Number parser step
    csd_pkg::num_phase_t np_n;
    logic                neg_n;
    logic [15:0]         cur_n;

    // Signed value of the field being closed
    logic [15:0]         field_val;

    logic                do_clear;

    assign field_val = neg_reg ? 16'(16'd0 - cur_reg) : cur_reg;

    // Start of a new field resets the number parser
    always_comb begin
        if (!infield_reg) begin
            fc_f  = (fcount_reg < csd_pkg::FIELD_MAX) ? fcount_reg + 3'd1 : fcount_reg;
            np_f  = csd_pkg::NP_LEAD;
            neg_f = 1'b0;
            cur_f = 16'd0;
        end else begin
            fc_f  = fcount_reg;
            np_f  = np_reg;
            neg_f = neg_reg;
            cur_f = cur_reg;
        end
    end

    // atoi-style number step: white space, sign, then digits
    always_comb begin
        np_n  = np_f;
        neg_n = neg_f;
        cur_n = cur_f;
        if (np_f == csd_pkg::NP_LEAD && csd_pkg::is_space(rx_byte)) begin
            np_n = csd_pkg::NP_LEAD;
        end else if (np_f == csd_pkg::NP_LEAD &&
                     (rx_byte == csd_pkg::CH_PLUS || rx_byte == csd_pkg::CH_MINUS)) begin
            neg_n = (rx_byte == csd_pkg::CH_MINUS);
            np_n  = csd_pkg::NP_DIGITS;
        end else if (np_f == csd_pkg::NP_LEAD || np_f == csd_pkg::NP_DIGITS) begin
            if (csd_pkg::is_digit(rx_byte)) begin
                np_n  = csd_pkg::NP_DIGITS;
                cur_n = 16'(cur_f * 16'd10 + {8'd0, rx_byte - csd_pkg::CH_ZERO});
            end else begin
                np_n = csd_pkg::NP_DONE;
            end
        end
    end

    // Next-state logic
    always_comb begin
        phase_next   = phase_reg;
        pcount_next  = pcount_reg;
        xor_next     = xor_reg;
        hexcnt_next  = hexcnt_reg;
        rxsum_next   = rxsum_reg;
        kw_next_s    = kw_reg;
        fcount_next  = fcount_reg;
        infield_next = infield_reg;
        np_next      = np_reg;
        neg_next     = neg_reg;
        cur_next     = cur_reg;
        num0_next    = num0_reg;
        num1_next    = num1_reg;
        num2_next    = num2_reg;
        do_clear     = 1'b0;

        if (rx_byte == csd_pkg::CH_NUL) begin
            phase_next = phase_reg;
        end else if (rx_byte == csd_pkg::CH_DOLLAR) begin
            do_clear   = 1'b1;
            phase_next = (phase_reg == csd_pkg::PH_IDLE) ? csd_pkg::PH_PAYLOAD
                                                         : csd_pkg::PH_IDLE;
        end else if (rx_byte == csd_pkg::CH_STAR) begin
            if (phase_reg != csd_pkg::PH_PAYLOAD) begin
                do_clear   = 1'b1;
                phase_next = csd_pkg::PH_IDLE;
            end else begin
                // close the open field
                infield_next = 1'b0;
                if (infield_reg) begin
                    if (fcount_reg == csd_pkg::NEED_ONE)   num0_next = field_val;
                    if (fcount_reg == csd_pkg::NEED_TWO)   num1_next = field_val;
                    if (fcount_reg == csd_pkg::NEED_THREE) num2_next = field_val;
                end
                phase_next = csd_pkg::PH_CHECK;
            end
        end else if (rx_byte == csd_pkg::CH_NL) begin
            do_clear   = 1'b1;
            phase_next = csd_pkg::PH_IDLE;
        end else if (phase_reg == csd_pkg::PH_PAYLOAD) begin
            if (pcount_reg >= CNT_LIMIT) begin
                do_clear   = 1'b1;
                phase_next = csd_pkg::PH_IDLE;
            end else begin
                pcount_next = pcount_reg + CNT_W'(1);
                xor_next    = xor_reg ^ rx_byte;
                if (rx_byte == csd_pkg::CH_COMMA) begin
                    infield_next = 1'b0;
                    if (infield_reg) begin
                        if (fcount_reg == csd_pkg::NEED_ONE)   num0_next = field_val;
                        if (fcount_reg == csd_pkg::NEED_TWO)   num1_next = field_val;
                        if (fcount_reg == csd_pkg::NEED_THREE) num2_next = field_val;
                    end
                end else begin
                    infield_next = 1'b1;
                    fcount_next  = fc_f;
                    if (fc_f == 3'd1) begin
                        kw_next_s = csd_pkg::kw_next(kw_reg, rx_byte);
                        np_next   = np_f;
                        neg_next  = neg_f;
                        cur_next  = cur_f;
                    end else begin
                        np_next  = np_n;
                        neg_next = neg_n;
                        cur_next = cur_n;
                    end
                end
            end
        end else if (phase_reg == csd_pkg::PH_CHECK) begin
            if (hexcnt_reg >= 2'd2) begin
                do_clear   = 1'b1;
                phase_next = csd_pkg::PH_IDLE;
            end else begin
                rxsum_next  = {rxsum_reg[3:0], csd_pkg::hex_value(rx_byte)};
                hexcnt_next = hexcnt_reg + 2'd1;
            end
        end

        // sentence restart clears everything except the phase
        if (do_clear) begin
            pcount_next  = '0;
            xor_next     = 8'd0;
            hexcnt_next  = 2'd0;
            rxsum_next   = 8'd0;
            kw_next_s    = csd_pkg::KW_START;
            fcount_next  = 3'd0;
            infield_next = 1'b0;
            np_next      = csd_pkg::NP_LEAD;
            neg_next     = 1'b0;
            cur_next     = 16'd0;
            num0_next    = 16'd0;
            num1_next    = 16'd0;
            num2_next    = 16'd0;
        end
    end

    // Result word for the current byte
    always_comb begin
        result = '0;
        if (rx_byte == csd_pkg::CH_NUL) begin
            result.error_flag = 1'b0;
        end else if (rx_byte == csd_pkg::CH_DOLLAR) begin
            result.error_flag = (phase_reg != csd_pkg::PH_IDLE);
        end else if (rx_byte == csd_pkg::CH_STAR) begin
            result.error_flag = (phase_reg != csd_pkg::PH_PAYLOAD);
        end else if (rx_byte == csd_pkg::CH_NL) begin
            if (phase_reg != csd_pkg::PH_CHECK || hexcnt_reg != 2'd2 ||
                rxsum_reg != xor_reg) begin
                result.error_flag = 1'b1;
            end else begin
                case (kw_reg)
                    csd_pkg::KW_CHA: begin
                        result.event_kind = csd_pkg::KIND_CHA;
                        result.event_valid = (fcount_reg == csd_pkg::NEED_ONE);
                    end
                    csd_pkg::KW_ACC: begin
                        result.event_kind = csd_pkg::KIND_ACC;
                        result.event_valid = (fcount_reg == csd_pkg::NEED_ONE);
                    end
                    csd_pkg::KW_REV: begin
                        result.event_kind = csd_pkg::KIND_REV;
                        result.event_valid = (fcount_reg == csd_pkg::NEED_ONE);
                    end
                    csd_pkg::KW_SHO: begin
                        result.event_kind = csd_pkg::KIND_SHO;
                        result.event_valid = (fcount_reg == csd_pkg::NEED_TWO);
                        result.value_b     = num1_reg;
                    end
                    csd_pkg::KW_RES: begin
                        result.event_kind = csd_pkg::KIND_RES;
                        result.event_valid = (fcount_reg == csd_pkg::NEED_THREE);
                        result.value_b     = num1_reg;
                        result.value_c     = num2_reg;
                    end
                    default: begin
                        result.event_valid = 1'b0;
                    end
                endcase
                result.value_a = num0_reg;
                // unknown keyword or wrong field count: error flagged, all other fields zero
                if (!result.event_valid) begin
                    result            = '0;
                    result.error_flag = 1'b1;
                end
            end
        end else if (phase_reg == csd_pkg::PH_PAYLOAD) begin
            result.error_flag = (pcount_reg >= CNT_LIMIT);
        end else if (phase_reg == csd_pkg::PH_CHECK) begin
            result.error_flag = (hexcnt_reg >= 2'd2);
        end
    end

    // State update, one word per step
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= csd_pkg::PH_IDLE;
            pcount_reg  <= '0;
            xor_reg     <= 8'd0;
            hexcnt_reg  <= 2'd0;
            rxsum_reg   <= 8'd0;
            kw_reg      <= csd_pkg::KW_START;
            fcount_reg  <= 3'd0;
            infield_reg <= 1'b0;
            np_reg      <= csd_pkg::NP_LEAD;
            neg_reg     <= 1'b0;
            cur_reg     <= 16'd0;
            num0_reg    <= 16'd0;
            num1_reg    <= 16'd0;
            num2_reg    <= 16'd0;
        end else if (step_en) begin
            phase_reg   <= phase_next;
            pcount_reg  <= pcount_next;
            xor_reg     <= xor_next;
            hexcnt_reg  <= hexcnt_next;
            rxsum_reg   <= rxsum_next;
            kw_reg      <= kw_next_s;
            fcount_reg  <= fcount_next;
            infield_reg <= infield_next;
            np_reg      <= np_next;
            neg_reg     <= neg_next;
            cur_reg     <= cur_next;
            num0_reg    <= num0_next;
            num1_reg    <= num1_next;
            num2_reg    <= num2_next;
        end
    end

endmodule

// ===== hw/rtl/checksummed_sentence_decoder_core.sv =====
// ============================================================================
// checksummed_sentence_decoder_core: XOR-checksummed sentence decoder
// Decodes "$payload*HH\n" sentences one byte per word into event words.
// ============================================================================
// Usage:
//   Input channel s_*: one received byte per word (s_rx_byte), valid/ready.
//   Result channel m_*: exactly one result word per input word, in order.
//   m_error_flag marks a byte that broke framing, length, checksum or
//   format; m_event_valid marks a newline that closed a good sentence, with
//   m_event_kind and up to three 16-bit values (unused values read 0).
//   An accepted word passes into the input register, then through the
//   decode logic into the result register.
//   Throughput is one word per cycle unless the receiver stalls; the sentence
//   state registers update once per word, so consecutive bytes need no gap.
//   Reset (aresetn low, synchronous) empties both registers and returns the
//   decoder to idle with all counters and stored numbers cleared.
//   When the receiver stalls, the result register holds its word and the
//   input register still takes one more word; s_ready drops only once both
//   are full, and no word is lost or repeated.
// ============================================================================
module checksummed_sentence_decoder_core #(
    parameter int MAX_PAYLOAD = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_error_flag,
    output logic        m_event_valid,
    output logic [2:0]  m_event_kind,
    output logic [15:0] m_value_a,
    output logic [15:0] m_value_b,
    output logic [15:0] m_value_c
);

    logic                 in_valid_reg, in_valid_next;
    logic [7:0]           in_byte_reg;
    logic                 out_valid_reg, out_valid_next;
    csd_pkg::csd_result_t out_reg;
    csd_pkg::csd_result_t step_result;
    logic                 out_adv;
    logic                 step_en;
    logic                 in_take;

    // Handshake and stage advance
    assign out_adv = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || out_adv;
    assign in_take = s_valid && s_ready;
    assign step_en = in_valid_reg && out_adv;

    assign in_valid_next  = in_take ? 1'b1 : (out_adv ? 1'b0 : in_valid_reg);
    assign out_valid_next = out_adv ? in_valid_reg : out_valid_reg;

    // Decode logic and sentence state
    csd_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .rx_byte (in_byte_reg),
        .result  (step_result)
    );

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
        if (in_take) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        if (step_en) begin
            out_reg <= step_result;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_error_flag  = out_reg.error_flag;
    assign m_event_valid = out_reg.event_valid;
    assign m_event_kind  = out_reg.event_kind;
    assign m_value_a     = out_reg.value_a;
    assign m_value_b     = out_reg.value_b;
    assign m_value_c     = out_reg.value_c;

endmodule

// ===== hw/rtl/csd_checker.sv =====
// ============================================================================
// csd_checker: port-level checks for the sentence decoder
// Watches the top-level ports and checks reset, stall and result coding.
// ============================================================================
module csd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_error_flag,
    input logic        m_event_valid,
    input logic [2:0]  m_event_kind,
    input logic [15:0] m_value_a,
    input logic [15:0] m_value_b,
    input logic [15:0] m_value_c
);

    // no result word right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // stalled result word holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_error_flag) &&
        $stable(m_event_valid) && $stable(m_event_kind) && $stable(m_value_a) &&
        $stable(m_value_b) && $stable(m_value_c))
        else $error("stalled result word changed");

    // an event and an error never share a word
    a_event_no_error: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_valid |-> !m_error_flag)
        else $error("event flagged together with error");

    // non-event words carry zero kind and values
    a_quiet_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_event_valid |-> m_event_kind == csd_pkg::KIND_CHA &&
        m_value_a == 16'd0 && m_value_b == 16'd0 && m_value_c == 16'd0)
        else $error("non-event word carries data");

    // single-number kinds leave the upper values at zero
    a_kind_values: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_valid && (m_event_kind == csd_pkg::KIND_CHA ||
        m_event_kind == csd_pkg::KIND_ACC || m_event_kind == csd_pkg::KIND_REV)
        |-> m_value_b == 16'd0 && m_value_c == 16'd0)
        else $error("extra values on single-number sentence");

endmodule

bind checksummed_sentence_decoder_core csd_checker u_csd_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_error_flag  (m_error_flag),
    .m_event_valid (m_event_valid),
    .m_event_kind  (m_event_kind),
    .m_value_a     (m_value_a),
    .m_value_b     (m_value_b),
    .m_value_c     (m_value_c)
);
